@@ design/mbss_pkg.sv @@
// ----------------------------------------------------------------------------
// mbss_pkg
// Shared constants for the masked byte signature scanner: field widths,
// control register indexes, reset values and parameter defaults.
// ----------------------------------------------------------------------------
package mbss_pkg;

   // item field widths
   localparam int DATA_W      = 8;
   localparam int MATCH_OFF_W = 32;

   // signature storage: two 64-bit words, bytes above this count are wildcards
   localparam int SIG_BYTES = 16;
   localparam int SIG_W     = 8 * SIG_BYTES;

   // stream byte counter, saturating
   localparam int SEEN_W = 33;

   // control port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;
   localparam int MASK_W     = 16;
   localparam int SLEN_W     = 5;
   localparam int REGION_W   = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_SIG_LOW   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIG_HIGH  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CARE_MASK = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SIG_LEN   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_REGION    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BACKWARD  = 3'd5;

   localparam logic [MASK_W-1:0]   CARE_MASK_RST = 16'hFFFF;
   localparam logic [SLEN_W-1:0]   SIG_LEN_RST   = 5'd1;
   localparam logic [REGION_W-1:0] REGION_RST    = 32'd1;

   // parameter defaults
   localparam int DEF_MAX_SIGNATURE_LEN = 16;
   localparam int DEF_OFFSET_BITS       = 32;

endpackage

@@ design/mbss_req_if.sv @@
// ----------------------------------------------------------------------------
// mbss_req_if
// Input channel of the scanner: one stream byte per item plus end marker.
// ----------------------------------------------------------------------------
interface mbss_req_if;
   import mbss_pkg::*;

   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] data_byte;
   logic              last;

   modport source (output valid, output data_byte, output last, input ready);
   modport sink   (input valid, input data_byte, input last, output ready);

endinterface

@@ design/mbss_rsp_if.sv @@
// ----------------------------------------------------------------------------
// mbss_rsp_if
// Result channel of the scanner: found flag and match offset per stream.
// ----------------------------------------------------------------------------
interface mbss_rsp_if;
   import mbss_pkg::*;

   logic                   valid;
   logic                   ready;
   logic                   found;
   logic [MATCH_OFF_W-1:0] match_offset;

   modport source (output valid, output found, output match_offset, input ready);
   modport sink   (input valid, input found, input match_offset, output ready);

endinterface

@@ design/masked_byte_signature_scanner.sv @@
// ----------------------------------------------------------------------------
// masked_byte_signature_scanner
// Wildcard byte pattern search over a byte stream, one byte per item.
//
//   port     | role        | handshake       | payload
//   ---------+-------------+-----------------+-------------------------------
//   req_ch   | byte input  | valid / ready   | data_byte, last
//   rsp_ch   | result      | valid / ready   | found, match_offset
//   csr_*    | config      | csr_we only     | csr_index, csr_wdata
//
// One item per cycle sustained unless a last-marked byte waits on a stalled
// result. An accepted byte sits in the input register while the window compare
// and match bookkeeping run on it, and the result of a last-marked byte lands
// in the result register at the next edge, from which the result is presented.
// A stalled result holds only last-marked bytes; other bytes keep flowing.
// Synchronous reset clears the window, counters and restores register
// defaults.
// ----------------------------------------------------------------------------
module masked_byte_signature_scanner #(
   parameter int MAX_SIGNATURE_LEN = mbss_pkg::DEF_MAX_SIGNATURE_LEN,
   parameter int OFFSET_BITS       = mbss_pkg::DEF_OFFSET_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   mbss_req_if.sink                        req_ch,
   mbss_rsp_if.source                      rsp_ch,
   input  logic                            csr_we,
   input  logic [mbss_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mbss_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import mbss_pkg::*;

   localparam int LEN_W = $clog2(MAX_SIGNATURE_LEN + 1);
   localparam int IDX_W = (MAX_SIGNATURE_LEN > 1) ? $clog2(MAX_SIGNATURE_LEN) : 1;
   localparam int NCMP  = (MAX_SIGNATURE_LEN < SIG_BYTES) ? MAX_SIGNATURE_LEN : SIG_BYTES;
   localparam logic [SEEN_W-1:0] SEEN_MAX = '1;

   // control registers
   logic [SIG_W/2-1:0]  cfg_sig_low_ff;
   logic [SIG_W/2-1:0]  cfg_sig_high_ff;
   logic [MASK_W-1:0]   cfg_mask_ff;
   logic [SLEN_W-1:0]   cfg_len_ff;
   logic [REGION_W-1:0] cfg_region_ff;
   logic                cfg_backward_ff;

   // input register
   logic              s1_valid_ff;
   logic [DATA_W-1:0] s1_byte_ff;
   logic              s1_last_ff;

   // stream state
   logic [DATA_W-1:0]      win_ff [MAX_SIGNATURE_LEN];
   logic [DATA_W-1:0]      win_sh [MAX_SIGNATURE_LEN];
   logic [DATA_W-1:0]      win_in [MAX_SIGNATURE_LEN];
   logic [SEEN_W-1:0]      seen_ff, seen_sh, seen_in;
   logic                   hit_ff, hit_upd, hit_in;
   logic [OFFSET_BITS-1:0] hit_off_ff, hit_off_upd, hit_off_in;

   // result register
   logic                   out_valid_ff;
   logic                   out_found_ff;
   logic [MATCH_OFF_W-1:0] out_off_ff;

   logic             proc;
   logic             out_free;
   logic [LEN_W-1:0] len;
   logic [SIG_W-1:0] sig;
   logic             match;
   logic [SEEN_W-1:0] start_pos;
   logic [SEEN_W-1:0] back_dist;
   logic [63:0]       fwd_ext, back_ext, hit_ext;

   assign sig      = {cfg_sig_high_ff, cfg_sig_low_ff};
   assign out_free = !out_valid_ff || rsp_ch.ready;
   // only a last-marked byte needs room in the result register
   assign proc     = s1_valid_ff && (!s1_last_ff || out_free);
   assign req_ch.ready = !s1_valid_ff || proc;

   // clamp signature length to 1..MAX_SIGNATURE_LEN
   always_comb begin
      logic [7:0] len8;
      len8 = 8'(cfg_len_ff);
      if (len8 == 8'd0) begin
         len8 = 8'd1;
      end else if (len8 > 8'(MAX_SIGNATURE_LEN)) begin
         len8 = 8'(MAX_SIGNATURE_LEN);
      end
      len = len8[LEN_W-1:0];
   end

   // shift the new byte in at the top of the window
   always_comb begin
      for (int i = 0; i < MAX_SIGNATURE_LEN - 1; i++) begin
         win_sh[i] = win_ff[i+1];
      end
      win_sh[MAX_SIGNATURE_LEN-1] = s1_byte_ff;
   end

   // masked compare of the newest len window bytes against the signature
   always_comb begin
      logic [LEN_W-1:0] pos;
      match = 1'b1;
      pos   = '0;
      for (int k = 0; k < NCMP; k++) begin
         if (LEN_W'(k) < len) begin
            pos = LEN_W'(MAX_SIGNATURE_LEN) - len + LEN_W'(k);
            if (cfg_mask_ff[k] && (win_sh[pos[IDX_W-1:0]] != sig[8*k +: 8])) begin
               match = 1'b0;
            end
         end
      end
   end

   always_comb begin
      seen_sh   = (seen_ff == SEEN_MAX) ? seen_ff : seen_ff + SEEN_W'(1);
      start_pos = seen_sh - SEEN_W'(len);
      back_dist = SEEN_W'(cfg_region_ff) - SEEN_W'(1) - start_pos;
      fwd_ext   = 64'(start_pos);
      back_ext  = 64'(back_dist);

      hit_upd     = hit_ff;
      hit_off_upd = hit_off_ff;
      if (seen_sh >= SEEN_W'(len) && match) begin
         if (!cfg_backward_ff) begin
            if (!hit_ff && seen_sh <= SEEN_W'(cfg_region_ff)) begin
               hit_upd     = 1'b1;
               hit_off_upd = fwd_ext[OFFSET_BITS-1:0];
            end
         end else if (start_pos < SEEN_W'(cfg_region_ff)) begin
            // latest match is nearest the base
            hit_upd     = 1'b1;
            hit_off_upd = back_ext[OFFSET_BITS-1:0];
         end
      end
      hit_ext = 64'(hit_off_upd);

      // clear stream state after the last byte
      for (int i = 0; i < MAX_SIGNATURE_LEN; i++) begin
         win_in[i] = s1_last_ff ? '0 : win_sh[i];
      end
      seen_in    = s1_last_ff ? '0 : seen_sh;
      hit_in     = s1_last_ff ? 1'b0 : hit_upd;
      hit_off_in = s1_last_ff ? '0 : hit_off_upd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_sig_low_ff  <= '0;
         cfg_sig_high_ff <= '0;
         cfg_mask_ff     <= CARE_MASK_RST;
         cfg_len_ff      <= SIG_LEN_RST;
         cfg_region_ff   <= REGION_RST;
         cfg_backward_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SIG_LOW:   cfg_sig_low_ff  <= csr_wdata;
            CSR_SIG_HIGH:  cfg_sig_high_ff <= csr_wdata;
            CSR_CARE_MASK: cfg_mask_ff     <= csr_wdata[MASK_W-1:0];
            CSR_SIG_LEN:   cfg_len_ff      <= csr_wdata[SLEN_W-1:0];
            CSR_REGION:    cfg_region_ff   <= csr_wdata[REGION_W-1:0];
            CSR_BACKWARD:  cfg_backward_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         s1_valid_ff <= req_ch.valid;
      end
      if (req_ch.ready && req_ch.valid) begin
         s1_byte_ff <= req_ch.data_byte;
         s1_last_ff <= req_ch.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_SIGNATURE_LEN; i++) begin
            win_ff[i] <= '0;
         end
         seen_ff    <= '0;
         hit_ff     <= 1'b0;
         hit_off_ff <= '0;
      end else if (proc) begin
         win_ff     <= win_in;
         seen_ff    <= seen_in;
         hit_ff     <= hit_in;
         hit_off_ff <= hit_off_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (proc && s1_last_ff) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
      if (proc && s1_last_ff) begin
         out_found_ff <= hit_upd;
         out_off_ff   <= hit_upd ? hit_ext[MATCH_OFF_W-1:0] : '0;
      end
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.found        = out_found_ff;
   assign rsp_ch.match_offset = out_off_ff;

   // a miss always reports offset zero
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.found |-> rsp_ch.match_offset == '0)
      else $error("result without match carries a nonzero offset");

   // stream state clears after the last byte
   a_stream_clear: assert property (@(posedge clock) disable iff (reset)
      proc && s1_last_ff |=> seen_ff == '0 && !hit_ff && hit_off_ff == '0)
      else $error("stream state not cleared after last byte");

   // byte counter advances by one per non-last byte until saturated
   a_seen_step: assert property (@(posedge clock) disable iff (reset)
      proc && !s1_last_ff && seen_ff != SEEN_MAX |=> seen_ff == $past(seen_ff) + SEEN_W'(1))
      else $error("byte counter did not advance");

   // an empty input register always takes an item
   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_ch.ready)
      else $error("input stalled while input register empty");

endmodule
